// ===== rtl/srtt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srtt_pkg: sorted range translation table shared definitions
// Field widths, command and status codes, register indexes and the
// per-entry compare result shared by the table and its compare unit.
// ----------------------------------------------------------------------------
package srtt_pkg;

    // Fixed field widths of the request and response
    localparam int VADDR_W   = 48;
    localparam int SIZE_W    = 20;
    localparam int BLOCK_W   = 16;
    localparam int PPN_W     = 36;
    localparam int CNT_OUT_W = 5;
    localparam int BSZ_W     = 11;
    localparam int SHIFT_W   = 5;
    localparam int CFG_W     = 11;
    localparam int MB_SHIFT  = 20;

    // Virtual address space actually decoded (no wider than VADDR_W)
    localparam int ADDR_BITS = 48;
    localparam logic [VADDR_W-1:0] VA_MASK = {VADDR_W{1'b1}} >> (VADDR_W - ADDR_BITS);

    // Default parameter values for the top level
    localparam int DEF_MAX_RANGES = 16;
    localparam int DEF_PAGE_BITS  = 12;

    // Register reset values
    localparam logic [BSZ_W-1:0]   BSZ_RESET   = 11'd128;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd15;

    // Configuration register indexes
    localparam logic REG_BLOCK_SIZE = 1'b0;
    localparam logic REG_PAGE_SHIFT = 1'b1;

    // Commands
    localparam logic CMD_INSERT    = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ALIGN    = 3'd1,
        ST_OVERLAP  = 3'd2,
        ST_FULL     = 3'd3,
        ST_UNMAPPED = 3'd4
    } t_status;

    // Result of comparing one held range against the request address
    typedef struct packed {
        logic below; // held start lies below the request address
        logic meet;  // held range and requested range share an address
        logic hit;   // request address falls inside the held range
    } t_cmp;

endpackage : srtt_pkg
`default_nettype wire

// ===== rtl/sorted_range_translation_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_range_translation_table: sorted virtual range table with lookup
// Holds up to MAX_RANGES ranges sorted by start address. Insert checks size
// alignment, overlap and room, then shifts the tail up and places the range.
// Translate scans for the range holding an address and returns its page.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                       payload
//  request   in         i_req_valid / o_req_stall       i_command, i_vaddr,
//                                                       i_size_mb, i_phys_block
//  response  out        o_rsp_valid / i_rsp_stall       o_status, o_phys_page,
//                                                       o_range_count
//  config    in         i_cfg_we (no handshake)         i_cfg_index, i_cfg_data
//
//  Sequence: one request at a time. A translate scans the held ranges,
//  then runs the page-math states (calc, add) and responds; an insert
//  scans, shifts the tail up, places the range and responds, while a
//  misaligned insert is answered straight from idle. The block goes back
//  to idle once the response is taken, and only then accepts the next
//  request. The single read port of the range RAM reads one entry per
//  cycle during scan and shift.
//  Reset: synchronous, active low; empties the table and loads register
//  defaults. No clearing pass, entries beyond the count are never read.
//  Stalls: a held response keeps o_req_stall high until it is taken.
// ----------------------------------------------------------------------------
module sorted_range_translation_table #(
    parameter int MAX_RANGES = srtt_pkg::DEF_MAX_RANGES,
    parameter int PAGE_BITS  = srtt_pkg::DEF_PAGE_BITS
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // request channel
    input  wire                           i_req_valid,
    output logic                          o_req_stall,
    input  wire                           i_command,
    input  wire [srtt_pkg::VADDR_W-1:0]   i_vaddr,
    input  wire [srtt_pkg::SIZE_W-1:0]    i_size_mb,
    input  wire [srtt_pkg::BLOCK_W-1:0]   i_phys_block,
    // response channel
    output logic                          o_rsp_valid,
    input  wire                           i_rsp_stall,
    output logic [2:0]                    o_status,
    output logic [srtt_pkg::PPN_W-1:0]    o_phys_page,
    output logic [srtt_pkg::CNT_OUT_W-1:0] o_range_count,
    // configuration write port
    input  wire                           i_cfg_we,
    input  wire                           i_cfg_index,
    input  wire [srtt_pkg::CFG_W-1:0]     i_cfg_data
);
    import srtt_pkg::*;

    localparam int IDX_W   = $clog2(MAX_RANGES);
    localparam int CNT_W   = $clog2(MAX_RANGES + 1);
    localparam int ENTRY_W = VADDR_W + SIZE_W + BLOCK_W;
    localparam int BASE_W  = BLOCK_W + 32;
    localparam int WIDE_W  = 64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_PLACE,
        S_CALC,
        S_ADD,
        S_RESP
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_count;
    logic [BSZ_W-1:0]    r_bsz;
    logic [SHIFT_W-1:0]  r_shift;

    // held request
    logic                r_cmd;
    logic [VADDR_W-1:0]  r_va;
    logic [SIZE_W-1:0]   r_size;
    logic [BLOCK_W-1:0]  r_blk;

    // scan and shift sequencing
    logic [CNT_W-1:0]    r_idx;    // next entry to read (shift: one above it)
    logic                r_pend;   // RAM read data is valid this cycle
    logic [IDX_W-1:0]    r_pidx;   // entry that the read data belongs to
    logic [CNT_W-1:0]    r_below;  // entries starting below the request

    // translate arithmetic
    logic [VADDR_W-1:0]  r_hit_start;
    logic [BLOCK_W-1:0]  r_hit_blk;
    logic [PPN_W-1:0]    r_off;
    logic [PPN_W-1:0]    r_base;

    // response
    logic                r_rsp_valid;
    t_status             r_status;
    logic [PPN_W-1:0]    r_page;

    // RAM and compare unit
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [VADDR_W-1:0]  ent_start;
    logic [SIZE_W-1:0]   ent_size;
    logic [BLOCK_W-1:0]  ent_blk;
    t_cmp                cmp;

    logic                issue_scan;
    logic                issue_shift;
    logic                misaligned;
    logic [WIDE_W-1:0]   vpn_va;
    logic [WIDE_W-1:0]   vpn_start;
    logic [BASE_W-1:0]   base_wide;
    logic [BSZ_W-1:0]    align_mask;

    assign {ent_start, ent_size, ent_blk} = ram_rdata;

    // Read one entry per cycle: ascending while scanning, descending while
    // moving the tail up to open a slot at the insert position.
    assign issue_scan  = (r_state == S_SCAN) && (r_idx < r_count);
    assign issue_shift = (r_state == S_SHIFT) && (r_idx > r_below);
    assign ram_raddr   = (r_state == S_SHIFT) ? IDX_W'(r_idx - 1'b1) : r_idx[IDX_W-1:0];

    // Shift writes each entry one slot up; place writes the new range.
    assign ram_we    = ((r_state == S_SHIFT) && r_pend) || (r_state == S_PLACE);
    assign ram_waddr = (r_state == S_PLACE) ? r_below[IDX_W-1:0] : IDX_W'(r_pidx + 1'b1);
    assign ram_wdata = (r_state == S_PLACE) ? {r_va, r_size, r_blk} : ram_rdata;

    // Size must be a multiple of the block size (mask taken in 11 bits)
    assign align_mask = r_bsz - 1'b1;
    assign misaligned = (i_size_mb[BSZ_W-1:0] & align_mask) != '0;

    // Page math: offset in pages from the range start, less one when the
    // start is not page aligned; base is the block's first page frame.
    assign vpn_va    = WIDE_W'(r_va) >> PAGE_BITS;
    assign vpn_start = WIDE_W'(r_hit_start) >> PAGE_BITS;
    assign base_wide = BASE_W'(r_hit_blk) << r_shift;

    srtt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_RANGES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    srtt_cmp u_cmp (
        .i_start    (ent_start),
        .i_size     (ent_size),
        .i_va       (r_va),
        .i_req_size (r_size),
        .o_res      (cmp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_bsz       <= BSZ_RESET;
            r_shift     <= SHIFT_RESET;
            r_rsp_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BLOCK_SIZE: r_bsz   <= i_cfg_data;
                    REG_PAGE_SHIFT: r_shift <= i_cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end

            // Track which entry the registered read data holds
            r_pend <= issue_scan || issue_shift;
            r_pidx <= ram_raddr;

            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_cmd   <= i_command;
                        r_va    <= i_vaddr & VA_MASK;
                        r_size  <= i_size_mb;
                        r_blk   <= i_phys_block;
                        r_idx   <= '0;
                        r_below <= '0;
                        if ((i_command == CMD_INSERT) && misaligned) begin
                            r_status    <= ST_ALIGN;
                            r_page      <= '0;
                            r_rsp_valid <= 1'b1;
                            r_state     <= S_RESP;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (issue_scan) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_pend) begin
                        if (cmp.below) begin
                            r_below <= r_below + 1'b1;
                        end
                        // Stop at the first hit or the first overlap
                        if ((r_cmd == CMD_TRANSLATE) && cmp.hit) begin
                            r_hit_start <= ent_start;
                            r_hit_blk   <= ent_blk;
                            r_state     <= S_CALC;
                        end else if ((r_cmd == CMD_INSERT) && cmp.meet) begin
                            r_status    <= ST_OVERLAP;
                            r_page      <= '0;
                            r_rsp_valid <= 1'b1;
                            r_state     <= S_RESP;
                        end
                    end else if (!issue_scan) begin
                        if (r_cmd == CMD_TRANSLATE) begin
                            r_status    <= ST_UNMAPPED;
                            r_page      <= '0;
                            r_rsp_valid <= 1'b1;
                            r_state     <= S_RESP;
                        end else if (r_count == CNT_W'(MAX_RANGES)) begin
                            r_status    <= ST_FULL;
                            r_page      <= '0;
                            r_rsp_valid <= 1'b1;
                            r_state     <= S_RESP;
                        end else begin
                            r_idx   <= r_count;
                            r_state <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    if (issue_shift) begin
                        r_idx <= r_idx - 1'b1;
                    end else if (!r_pend) begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    r_count     <= r_count + 1'b1;
                    r_status    <= ST_OK;
                    r_page      <= '0;
                    r_rsp_valid <= 1'b1;
                    r_state     <= S_RESP;
                end
                S_CALC: begin
                    r_off   <= vpn_va[PPN_W-1:0] - vpn_start[PPN_W-1:0]
                               - PPN_W'(r_hit_start[PAGE_BITS-1:0] != '0);
                    r_base  <= base_wide[PPN_W-1:0];
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_page      <= r_base + r_off;
                    r_status    <= ST_OK;
                    r_rsp_valid <= 1'b1;
                    r_state     <= S_RESP;
                end
                S_RESP: begin
                    // Hold the response until the consumer takes it
                    if (!i_rsp_stall) begin
                        r_rsp_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_stall   = (r_state != S_IDLE);
    assign o_rsp_valid   = r_rsp_valid;
    assign o_status      = r_status;
    assign o_phys_page   = r_page;
    assign o_range_count = CNT_OUT_W'(r_count);

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_RANGES))
        else $error("range count above table depth");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && (r_status == ST_FULL)) |-> (r_count == CNT_W'(MAX_RANGES)))
        else $error("table full reported with free room");

    a_page_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && (r_status != ST_OK)) |-> (r_page == '0))
        else $error("nonzero page on a failed request");

    a_write_only_on_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_cmd == CMD_INSERT))
        else $error("table written during a translate");

    a_count_moves_on_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> ($past(r_state) == S_PLACE))
        else $error("range count changed outside placement");
`endif

endmodule : sorted_range_translation_table
`default_nettype wire

// ===== rtl/srtt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srtt_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module srtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : srtt_ram
`default_nettype wire

// ===== rtl/srtt_cmp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srtt_cmp: range compare unit
// Compares one held range with the request: the distance between the starts
// (lower start subtracted from higher) is compared against both range lengths.
// ----------------------------------------------------------------------------
module srtt_cmp (
    input  wire [srtt_pkg::VADDR_W-1:0] i_start,
    input  wire [srtt_pkg::SIZE_W-1:0]  i_size,
    input  wire [srtt_pkg::VADDR_W-1:0] i_va,
    input  wire [srtt_pkg::SIZE_W-1:0]  i_req_size,
    output srtt_pkg::t_cmp              o_res
);
    import srtt_pkg::*;

    logic                 below;
    logic                 equal;
    logic [VADDR_W-1:0]   gap;
    logic [VADDR_W-1:0]   len_held;
    logic [VADDR_W-1:0]   len_req;
    logic                 in_held;
    logic                 in_req;

    assign below    = i_start < i_va;
    assign equal    = i_start == i_va;
    assign gap      = below ? (i_va - i_start) : (i_start - i_va);
    assign len_held = VADDR_W'({i_size, {MB_SHIFT{1'b0}}});
    assign len_req  = VADDR_W'({i_req_size, {MB_SHIFT{1'b0}}});
    assign in_held  = gap < len_held;
    assign in_req   = gap < len_req;

    assign o_res.below = below;
    assign o_res.meet  = (i_size != '0) && (i_req_size != '0) && (below ? in_held : in_req);
    assign o_res.hit   = (below || equal) && in_held;

endmodule : srtt_cmp
`default_nettype wire
